// File: src/sffi2c_pkg.sv
// shared types and constants of the eeprom i2c master
package sffi2c_pkg;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_LOAD     = 3'd1,
        OP_READ     = 3'd2,
        OP_WRITE    = 3'd3,
        OP_RECOVER  = 3'd4
    } opcode_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ADDR_NACK = 3'd1;
    localparam logic [2:0] ST_REG_NACK  = 3'd2;
    localparam logic [2:0] ST_RADR_NACK = 3'd3;
    localparam logic [2:0] ST_DATA_NACK = 3'd4;
    localparam logic [2:0] ST_BAD_LEN   = 3'd5;

    localparam logic [15:0] PHASE_RESET   = 16'd400;
    localparam logic [15:0] STRETCH_RESET = 16'd2500;

    localparam logic [0:0] CFG_PHASE   = 1'b0;
    localparam logic [0:0] CFG_STRETCH = 1'b1;

    // one tick as it travels from the front to the engine
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] dev_address;
        logic [7:0] reg_address;
        logic [7:0] length;
        logic [2:0] buffer_index;
        logic [7:0] data_byte;
        logic       scl_level;
        logic       sda_level;
    } tick_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] byte_count;
    } result_t;

endpackage

// File: src/sffi2c_front.sv
// input stage and two-entry queue in front of the bus engine
module sffi2c_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sffi2c_pkg::tick_t in_tick,
    output logic              q_valid,
    input  logic              q_ready,
    output sffi2c_pkg::tick_t q_tick
);
    sffi2c_pkg::tick_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_tick   = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_tick;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && cnt_reg == 2'd1 |=> cnt_reg == 2'd2) else $error("bad count");
`endif
endmodule

// File: src/sffi2c_engine.sv
// i2c bus sequencer, one tick per accepted item, registered result
module sffi2c_engine #(
    parameter int WRITE_DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         phase_ticks,
    input  logic [15:0]         stretch_ticks,
    input  logic                q_valid,
    output logic                q_ready,
    input  sffi2c_pkg::tick_t   q_tick,
    output logic                r_valid,
    input  logic                r_ready,
    output sffi2c_pkg::result_t r_res
);
    localparam int IW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_W, PH_ST_A, PH_ST_B, PH_ST_C,
        PH_BIT_A, PH_BIT_B, PH_BIT_W, PH_BIT_C, PH_BIT_D,
        PH_SP_A, PH_SP_B, PH_SP_W, PH_SP_C, PH_SP_D,
        PH_RT_A, PH_RT_B
    } phase_t;

    typedef enum logic [3:0] {
        STG_NONE, STG_START1, STG_DEVW, STG_REG, STG_MIDSTOP, STG_START2,
        STG_DEVR, STG_RDATA, STG_WDATA, STG_ENDSTOP, STG_RCLK, STG_RSTART
    } stage_t;

    phase_t      ph_reg, ph_next;
    stage_t      stg_reg, stg_next;
    logic [15:0] pc_reg, pc_next, sc_reg, sc_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  sh_reg, sh_next, bd_reg, bd_next, bt_reg, bt_next;
    logic [7:0]  dev_reg, dev_next, ra_reg, ra_next;
    logic [2:0]  err_reg, err_next;
    logic        scl_reg, scl_next, sda_reg, sda_next, ack_reg, ack_next;
    logic        opw_reg, opw_next;
    logic [7:0]  wbuf [WRITE_DEPTH];
    logic        outv_reg;
    sffi2c_pkg::result_t res_reg, res_next;
    logic        step;
    logic [15:0] lim;
    logic        d_over, w_over;
    logic [7:0]  bd_inc;
    logic [IW-1:0] widx;

    // the result register may hold one result; a new tick passes only when it frees
    assign q_ready = !outv_reg || r_ready;
    assign step    = q_valid && q_ready;
    assign r_valid = outv_reg;
    assign r_res   = res_reg;

    assign lim    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign d_over = (pc_reg + 16'd1) >= lim;
    assign w_over = q_tick.scl_level || ((sc_reg + 16'd1) >= stretch_ticks);
    assign bd_inc = bd_reg + 8'd1;
    assign widx   = IW'({29'd0, q_tick.buffer_index});

    function automatic logic [7:0] buf_at(input logic [7:0] i);
        logic [7:0] v;
        v = 8'd0;
        for (int k = 0; k < WRITE_DEPTH; k++) begin
            if (i == 8'(k)) begin
                // a slot loaded by this same tick goes out with its new byte
                if (q_tick.opcode == sffi2c_pkg::OP_LOAD &&
                    {5'd0, q_tick.buffer_index} == 8'(k))
                    v = q_tick.data_byte;
                else
                    v = wbuf[k];
            end
        end
        return v;
    endfunction

    always_comb begin
        logic        en;
        phase_t      tgt;
        logic        bdl;
        ph_next = ph_reg; stg_next = stg_reg;
        pc_next = pc_reg; sc_next = sc_reg; bit_next = bit_reg;
        sh_next = sh_reg; bd_next = bd_reg; bt_next = bt_reg;
        dev_next = dev_reg; ra_next = ra_reg; err_next = err_reg;
        scl_next = scl_reg; sda_next = sda_reg; ack_next = ack_reg; opw_next = opw_reg;
        res_next = '0;
        en = 1'b0; tgt = PH_IDLE;
        bdl = 1'b0;

        if (ph_reg != PH_IDLE) begin
            unique case (ph_reg)
                PH_ST_W: begin
                    sc_next = sc_reg + 16'd1;
                    if (w_over) begin en = 1'b1; tgt = PH_ST_A; end
                end
                PH_ST_A, PH_ST_B, PH_BIT_A, PH_BIT_B, PH_SP_A, PH_SP_B, PH_SP_C,
                PH_RT_A: begin
                    pc_next = pc_reg + 16'd1;
                    if (d_over) begin
                        en = 1'b1;
                        unique case (ph_reg)
                            PH_ST_A:  tgt = PH_ST_B;
                            PH_ST_B:  tgt = PH_ST_C;
                            PH_BIT_A: tgt = PH_BIT_B;
                            PH_BIT_B: tgt = PH_BIT_W;
                            PH_SP_A:  tgt = PH_SP_B;
                            PH_SP_B:  tgt = PH_SP_W;
                            PH_SP_C:  tgt = PH_SP_D;
                            default:  tgt = PH_RT_B;
                        endcase
                    end
                end
                PH_BIT_W, PH_SP_W: begin
                    sc_next = sc_reg + 16'd1;
                    if (w_over) begin
                        en = 1'b1;
                        tgt = (ph_reg == PH_BIT_W) ? PH_BIT_C : PH_SP_C;
                    end
                end
                PH_ST_C: begin
                    pc_next = pc_reg + 16'd1;
                    if (d_over) begin
                        scl_next = 1'b1;
                        en = 1'b1;
                        if (stg_reg == STG_START1) begin
                            stg_next = STG_DEVW; sh_next = dev_reg & 8'hfe;
                            bit_next = 4'd0; tgt = PH_BIT_A;
                        end else if (stg_reg == STG_START2) begin
                            stg_next = STG_DEVR; sh_next = dev_reg | 8'h01;
                            bit_next = 4'd0; tgt = PH_BIT_A;
                        end else begin
                            tgt = PH_RT_A;
                        end
                    end
                end
                PH_BIT_C: begin
                    pc_next = pc_reg + 16'd1;
                    if (d_over) begin
                        if (bit_reg >= 4'd8) ack_next = q_tick.sda_level;
                        else if (stg_reg == STG_RDATA) sh_next = {sh_reg[6:0], q_tick.sda_level};
                        else sh_next = {sh_reg[6:0], 1'b0};
                        en = 1'b1; tgt = PH_BIT_D;
                    end
                end
                PH_BIT_D: begin
                    pc_next = pc_reg + 16'd1;
                    if (d_over) begin
                        bit_next = bit_reg + 4'd1;
                        en = 1'b1;
                        if (bit_reg + 4'd1 < 4'd9) begin
                            tgt = PH_BIT_A;
                        end else begin
                            scl_next = 1'b1;
                            bit_next = 4'd0;
                            tgt = PH_BIT_A;
                            priority case (stg_reg)
                                STG_DEVW: begin
                                    if (ack_reg) begin
                                        err_next = sffi2c_pkg::ST_ADDR_NACK;
                                        stg_next = STG_ENDSTOP; tgt = PH_SP_A;
                                    end else begin
                                        stg_next = STG_REG; sh_next = ra_reg;
                                    end
                                end
                                STG_REG: begin
                                    if (ack_reg) begin
                                        err_next = sffi2c_pkg::ST_REG_NACK;
                                        stg_next = STG_ENDSTOP; tgt = PH_SP_A;
                                    end else if (opw_reg) begin
                                        stg_next = STG_WDATA; sh_next = buf_at(8'd0);
                                    end else begin
                                        stg_next = STG_MIDSTOP; tgt = PH_SP_A;
                                    end
                                end
                                STG_DEVR: begin
                                    if (ack_reg) begin
                                        err_next = sffi2c_pkg::ST_RADR_NACK;
                                        stg_next = STG_ENDSTOP; tgt = PH_SP_A;
                                    end else begin
                                        stg_next = STG_RDATA; sh_next = 8'd0;
                                    end
                                end
                                STG_RDATA: begin
                                    res_next.read_data  = sh_reg;
                                    res_next.read_valid = 1'b1;
                                    res_next.read_last  = ({1'b0, bd_reg} + 9'd1) >= {1'b0, bt_reg};
                                    bd_next = bd_inc;
                                    if (res_next.read_last) begin
                                        err_next = sffi2c_pkg::ST_OK;
                                        stg_next = STG_ENDSTOP; tgt = PH_SP_A;
                                    end else begin
                                        sh_next = 8'd0;
                                    end
                                end
                                STG_WDATA: begin
                                    if (ack_reg) begin
                                        err_next = sffi2c_pkg::ST_DATA_NACK;
                                        stg_next = STG_ENDSTOP; tgt = PH_SP_A;
                                    end else begin
                                        bd_next = bd_inc;
                                        if (bd_inc >= bt_reg) begin
                                            err_next = sffi2c_pkg::ST_OK;
                                            stg_next = STG_ENDSTOP; tgt = PH_SP_A;
                                        end else begin
                                            sh_next = buf_at(bd_inc);
                                        end
                                    end
                                end
                                STG_RCLK: begin
                                    stg_next = STG_RSTART; tgt = PH_ST_W;
                                end
                                default: begin
                                    err_next = sffi2c_pkg::ST_OK;
                                    res_next.done_res = 1'b1;
                                    stg_next = STG_NONE; tgt = PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
                PH_SP_D: begin
                    pc_next = pc_reg + 16'd1;
                    if (d_over) begin
                        en = 1'b1;
                        if (stg_reg == STG_MIDSTOP) begin
                            stg_next = STG_START2; tgt = PH_ST_W;
                        end else begin
                            res_next.done_res   = 1'b1;
                            res_next.status     = err_reg;
                            res_next.byte_count = (err_reg != 3'd0) ? 8'd0 : bd_reg;
                            stg_next = STG_NONE; tgt = PH_IDLE;
                        end
                    end
                end
                PH_RT_B: begin
                    pc_next = pc_reg + 16'd1;
                    if (d_over) begin
                        err_next = sffi2c_pkg::ST_OK;
                        res_next.done_res = 1'b1;
                        stg_next = STG_NONE; en = 1'b1; tgt = PH_IDLE;
                    end
                end
                default: begin
                    stg_next = STG_NONE; en = 1'b1; tgt = PH_IDLE;
                end
            endcase
        end else if (q_tick.opcode == sffi2c_pkg::OP_READ ||
                     q_tick.opcode == sffi2c_pkg::OP_WRITE) begin
            opw_next = (q_tick.opcode == sffi2c_pkg::OP_WRITE);
            if (q_tick.length == 8'd0 ||
                (opw_next && {24'd0, q_tick.length} > 32'(WRITE_DEPTH))) begin
                err_next = sffi2c_pkg::ST_BAD_LEN;
                res_next.done_res = 1'b1;
                res_next.status   = sffi2c_pkg::ST_BAD_LEN;
                stg_next = STG_NONE; en = 1'b1; tgt = PH_IDLE;
            end else begin
                dev_next = q_tick.dev_address; ra_next = q_tick.reg_address;
                bt_next = q_tick.length; bd_next = 8'd0; err_next = 3'd0;
                ack_next = 1'b0; stg_next = STG_START1; en = 1'b1; tgt = PH_ST_W;
            end
        end else if (q_tick.opcode == sffi2c_pkg::OP_RECOVER) begin
            opw_next = 1'b0; bd_next = 8'd0; bt_next = 8'd0; err_next = 3'd0;
            stg_next = STG_RCLK; sh_next = 8'hff; bit_next = 4'd0;
            en = 1'b1; tgt = PH_BIT_A;
        end

        // phase entry actions, with the drive of sda taken from the new byte state
        if (en) begin
            ph_next = tgt; pc_next = 16'd0; sc_next = 16'd0;
            if (stg_next == STG_RCLK) bdl = 1'b0;
            else if (stg_next == STG_RDATA)
                bdl = (bit_next >= 4'd8) && (({1'b0, bd_next} + 9'd1) < {1'b0, bt_next});
            else bdl = (bit_next < 4'd8) ? !sh_next[7] : 1'b0;
            unique case (tgt)
                PH_ST_W, PH_IDLE: begin scl_next = 1'b0; sda_next = 1'b0; end
                PH_ST_C, PH_SP_B: sda_next = 1'b1;
                PH_BIT_A, PH_SP_A, PH_RT_A: scl_next = 1'b1;
                PH_BIT_B: sda_next = bdl;
                PH_BIT_W, PH_SP_W: scl_next = 1'b0;
                PH_SP_D, PH_RT_B: sda_next = 1'b0;
                default: ;
            endcase
        end

        res_next.scl_drive_low = scl_next;
        res_next.sda_drive_low = sda_next;
        res_next.busy_res      = (ph_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_IDLE; stg_reg <= STG_NONE;
            pc_reg <= '0; sc_reg <= '0; bit_reg <= '0;
            sh_reg <= '0; bd_reg <= '0; bt_reg <= '0;
            dev_reg <= '0; ra_reg <= '0; err_reg <= '0;
            scl_reg <= 1'b0; sda_reg <= 1'b0; ack_reg <= 1'b0; opw_reg <= 1'b0;
            outv_reg <= 1'b0;
        end else begin
            if (step) begin
                ph_reg <= ph_next; stg_reg <= stg_next;
                pc_reg <= pc_next; sc_reg <= sc_next; bit_reg <= bit_next;
                sh_reg <= sh_next; bd_reg <= bd_next; bt_reg <= bt_next;
                dev_reg <= dev_next; ra_reg <= ra_next; err_reg <= err_next;
                scl_reg <= scl_next; sda_reg <= sda_next; ack_reg <= ack_next;
                opw_reg <= opw_next;
            end
            if (step) outv_reg <= 1'b1;
            else if (r_ready) outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) res_reg <= res_next;
    end

    // write buffer slots, loaded regardless of the sequencer
    always_ff @(posedge aclk) begin
        if (step && q_tick.opcode == sffi2c_pkg::OP_LOAD &&
            {29'd0, q_tick.buffer_index} < 32'(WRITE_DEPTH))
            wbuf[widx] <= q_tick.data_byte;
    end

`ifndef SYNTHESIS
    a_idle_released: assert property (@(posedge aclk) disable iff (!aresetn)
        ph_reg == PH_IDLE |-> !scl_reg && !sda_reg) else $error("idle bus not released");
    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg <= 4'd8) else $error("bit counter out of range");
    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(step) && $past(aresetn) |-> $stable(ph_reg)) else $error("state moved w/o tick");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_next.done_res |=> ph_reg == PH_IDLE) else $error("done while busy");
`endif
endmodule

// File: src/sff_eeprom_i2c_master_unit.sv
// top level of the eeprom i2c master: register port, tick queue, bus engine
//  channel | ports             | moves
//  s_      | s_valid/s_ready   | one bus tick (opcode, addresses, sampled lines)
//  m_      | m_valid/m_ready   | one result per tick (drives, read byte, status)
//  apb     | psel/penable/...  | phase_ticks at 0x0, stretch_ticks at 0x4
// one tick transfer is taken every cycle while s_ready is high; the engine steps the bus sequencer once per tick
// a tick taken into the queue steps the engine as it leaves it, and its result is held in the result register
// the result register frees as it is taken, so stalls on m_ pass back through a two-entry
// queue to s_ready; reset (aresetn, synchronous) idles the bus and loads default timings
// the write buffer holds no reset value until loaded
module sff_eeprom_i2c_master_unit #(
    parameter int WRITE_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [7:0]  s_dev_address,
    input  logic [7:0]  s_reg_address,
    input  logic [7:0]  s_length,
    input  logic [2:0]  s_buffer_index,
    input  logic [7:0]  s_data_byte,
    input  logic        s_scl_level,
    input  logic        s_sda_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_drive_low,
    output logic        m_sda_drive_low,
    output logic        m_busy_res,
    output logic [7:0]  m_read_data,
    output logic        m_read_valid,
    output logic        m_read_last,
    output logic        m_done_res,
    output logic [2:0]  m_status,
    output logic [7:0]  m_byte_count
);
    logic [15:0] phase_reg, stretch_reg;
    sffi2c_pkg::tick_t   in_tick, q_tick;
    sffi2c_pkg::result_t res;
    logic q_valid, q_ready;
    logic wr_en;

    // register file; writes land on the access cycle
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= sffi2c_pkg::PHASE_RESET;
            stretch_reg <= sffi2c_pkg::STRETCH_RESET;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            if (paddr[2] == sffi2c_pkg::CFG_PHASE) phase_reg <= pwdata[15:0];
            else stretch_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == sffi2c_pkg::CFG_STRETCH) prdata = {16'd0, stretch_reg};
        else prdata = {16'd0, phase_reg};
    end

    always_comb begin
        in_tick.opcode       = s_opcode;
        in_tick.dev_address  = s_dev_address;
        in_tick.reg_address  = s_reg_address;
        in_tick.length       = s_length;
        in_tick.buffer_index = s_buffer_index;
        in_tick.data_byte    = s_data_byte;
        in_tick.scl_level    = s_scl_level;
        in_tick.sda_level    = s_sda_level;
    end

    sffi2c_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_tick  (in_tick),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_tick   (q_tick)
    );

    sffi2c_engine #(.WRITE_DEPTH(WRITE_DEPTH)) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .phase_ticks   (phase_reg),
        .stretch_ticks (stretch_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_tick        (q_tick),
        .r_valid       (m_valid),
        .r_ready       (m_ready),
        .r_res         (res)
    );

    assign m_scl_drive_low = res.scl_drive_low;
    assign m_sda_drive_low = res.sda_drive_low;
    assign m_busy_res      = res.busy_res;
    assign m_read_data     = res.read_data;
    assign m_read_valid    = res.read_valid;
    assign m_read_last     = res.read_last;
    assign m_done_res      = res.done_res;
    assign m_status        = res.status;
    assign m_byte_count    = res.byte_count;
endmodule

// File: tb/tb_sff_eeprom_i2c_master_unit.sv
// testbench of the eeprom i2c master unit: directed table, random bus sequences, self-checking
`timescale 1ns / 100ps

module tb_sff_eeprom_i2c_master_unit;

    localparam int WDEPTH     = 8;
    localparam int CYCLE_MAX  = 1000000;
    localparam int TAIL_WAIT  = 20;

    // bus sequencer phases of the predictor
    localparam int PH_IDLE  = 0;
    localparam int PH_ST_W  = 1;
    localparam int PH_ST_A  = 2;
    localparam int PH_ST_B  = 3;
    localparam int PH_ST_C  = 4;
    localparam int PH_BIT_A = 5;
    localparam int PH_BIT_B = 6;
    localparam int PH_BIT_W = 7;
    localparam int PH_BIT_C = 8;
    localparam int PH_BIT_D = 9;
    localparam int PH_SP_A  = 10;
    localparam int PH_SP_B  = 11;
    localparam int PH_SP_W  = 12;
    localparam int PH_SP_C  = 13;
    localparam int PH_SP_D  = 14;
    localparam int PH_RT_A  = 15;
    localparam int PH_RT_B  = 16;

    // transaction stages
    localparam int SG_NONE    = 0;
    localparam int SG_START1  = 1;
    localparam int SG_DEVW    = 2;
    localparam int SG_REG     = 3;
    localparam int SG_MIDSTOP = 4;
    localparam int SG_START2  = 5;
    localparam int SG_DEVR    = 6;
    localparam int SG_RDATA   = 7;
    localparam int SG_WDATA   = 8;
    localparam int SG_ENDSTOP = 9;
    localparam int SG_RCLK    = 10;
    localparam int SG_RSTART  = 11;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = '0;
    logic [7:0]  s_dev_address = '0, s_reg_address = '0, s_length = '0, s_data_byte = '0;
    logic [2:0]  s_buffer_index = '0;
    logic        s_scl_level = 1'b1, s_sda_level = 1'b1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_scl_drive_low, m_sda_drive_low, m_busy_res;
    logic [7:0]  m_read_data, m_byte_count;
    logic        m_read_valid, m_read_last, m_done_res;
    logic [2:0]  m_status;

    sff_eeprom_i2c_master_unit #(.WRITE_DEPTH(WDEPTH)) u_top (.*);

    always #6 aclk = ~aclk;

    // run guard: cycle counter with a generous limit
    int unsigned cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // predicted bus engine state
    int unsigned phase_lim_cfg, stretch_lim_cfg;
    int unsigned seq_ph, ph_cnt, str_cnt, bit_cnt, stg;
    int unsigned shreg, nbytes, ntotal, dev_a, reg_a, err_st;
    logic [7:0]  wbuf [WDEPTH];
    bit          scl_d, sda_d, ack_bit, is_write;
    sffi2c_pkg::result_t cur;

    sffi2c_pkg::result_t pending_results [$];
    int unsigned n_items = 0, n_results = 0, n_errors = 0;
    int unsigned n_done = 0, n_reads = 0, n_nacks = 0;
    bit          quiet = 1'b0;       // no idling in the last part
    bit          hold_req = 1'b0;    // ask the receiver for a long hold-off

    function automatic bit sda_for_bit();
        if (stg == SG_RCLK) return 1'b0;
        if (stg == SG_RDATA) begin
            if (bit_cnt < 8) return 1'b0;
            return (nbytes + 1 < ntotal);
        end
        if (bit_cnt < 8) return !shreg[7];
        return 1'b0;
    endfunction

    function automatic void go_phase(int unsigned p);
        seq_ph = p;
        ph_cnt = 0;
        str_cnt = 0;
        case (p)
            PH_ST_W:  begin scl_d = 0; sda_d = 0; end
            PH_ST_C:  sda_d = 1;
            PH_BIT_A: scl_d = 1;
            PH_BIT_B: sda_d = sda_for_bit();
            PH_BIT_W: scl_d = 0;
            PH_SP_A:  scl_d = 1;
            PH_SP_B:  sda_d = 1;
            PH_SP_W:  scl_d = 0;
            PH_SP_D:  sda_d = 0;
            PH_RT_A:  scl_d = 1;
            PH_RT_B:  sda_d = 0;
            PH_IDLE:  begin scl_d = 0; sda_d = 0; end
            default: ;
        endcase
    endfunction

    function automatic void close_xfer(int unsigned st, int unsigned cnt);
        err_st = st & 7;
        cur.done_res = 1'b1;
        cur.status = st[2:0];
        cur.byte_count = cnt[7:0];
        stg = SG_NONE;
        go_phase(PH_IDLE);
    endfunction

    function automatic void load_byte(int unsigned s, int unsigned v);
        stg = s;
        shreg = v & 8'hff;
        bit_cnt = 0;
        go_phase(PH_BIT_A);
    endfunction

    function automatic void stop_with(int unsigned e);
        err_st = e;
        stg = SG_ENDSTOP;
        go_phase(PH_SP_A);
    endfunction

    function automatic bit phase_elapsed();
        int unsigned lim;
        lim = (phase_lim_cfg != 0) ? phase_lim_cfg : 1;
        ph_cnt++;
        return ph_cnt >= lim;
    endfunction

    function automatic bit scl_wait_over(bit scl);
        if (scl) return 1'b1;
        str_cnt++;
        return str_cnt >= stretch_lim_cfg;
    endfunction

    function automatic void byte_finished();
        case (stg)
            SG_DEVW:
                if (ack_bit) stop_with(sffi2c_pkg::ST_ADDR_NACK);
                else load_byte(SG_REG, reg_a);
            SG_REG:
                if (ack_bit) stop_with(sffi2c_pkg::ST_REG_NACK);
                else if (is_write) load_byte(SG_WDATA, wbuf[0]);
                else begin
                    stg = SG_MIDSTOP;
                    go_phase(PH_SP_A);
                end
            SG_DEVR:
                if (ack_bit) stop_with(sffi2c_pkg::ST_RADR_NACK);
                else load_byte(SG_RDATA, 0);
            SG_RDATA: begin
                cur.read_data = shreg[7:0];
                cur.read_valid = 1'b1;
                cur.read_last = (nbytes + 1 >= ntotal);
                nbytes = (nbytes + 1) & 8'hff;
                if (cur.read_last) stop_with(sffi2c_pkg::ST_OK);
                else load_byte(SG_RDATA, 0);
            end
            SG_WDATA:
                if (ack_bit) stop_with(sffi2c_pkg::ST_DATA_NACK);
                else begin
                    nbytes = (nbytes + 1) & 8'hff;
                    if (nbytes >= ntotal) stop_with(sffi2c_pkg::ST_OK);
                    else load_byte(SG_WDATA, wbuf[nbytes]);
                end
            SG_RCLK: begin
                stg = SG_RSTART;
                go_phase(PH_ST_W);
            end
            default: close_xfer(sffi2c_pkg::ST_OK, 0);
        endcase
    endfunction

    function automatic void step_engine(bit scl, bit sda);
        case (seq_ph)
            PH_ST_W: if (scl_wait_over(scl)) go_phase(PH_ST_A);
            PH_ST_A: if (phase_elapsed()) go_phase(PH_ST_B);
            PH_ST_B: if (phase_elapsed()) go_phase(PH_ST_C);
            PH_ST_C:
                if (phase_elapsed()) begin
                    scl_d = 1;
                    if (stg == SG_START1) load_byte(SG_DEVW, dev_a & 8'hfe);
                    else if (stg == SG_START2) load_byte(SG_DEVR, dev_a | 1);
                    else go_phase(PH_RT_A);
                end
            PH_BIT_A: if (phase_elapsed()) go_phase(PH_BIT_B);
            PH_BIT_B: if (phase_elapsed()) go_phase(PH_BIT_W);
            PH_BIT_W: if (scl_wait_over(scl)) go_phase(PH_BIT_C);
            PH_BIT_C:
                if (phase_elapsed()) begin
                    if (bit_cnt >= 8) ack_bit = sda;
                    else if (stg == SG_RDATA) shreg = ((shreg << 1) | sda) & 8'hff;
                    else shreg = (shreg << 1) & 8'hff;
                    go_phase(PH_BIT_D);
                end
            PH_BIT_D:
                if (phase_elapsed()) begin
                    bit_cnt++;
                    if (bit_cnt < 9) go_phase(PH_BIT_A);
                    else begin
                        scl_d = 1;
                        byte_finished();
                    end
                end
            PH_SP_A: if (phase_elapsed()) go_phase(PH_SP_B);
            PH_SP_B: if (phase_elapsed()) go_phase(PH_SP_W);
            PH_SP_W: if (scl_wait_over(scl)) go_phase(PH_SP_C);
            PH_SP_C: if (phase_elapsed()) go_phase(PH_SP_D);
            PH_SP_D:
                if (phase_elapsed()) begin
                    if (stg == SG_MIDSTOP) begin
                        stg = SG_START2;
                        go_phase(PH_ST_W);
                    end else close_xfer(err_st, (err_st != 0) ? 0 : nbytes);
                end
            PH_RT_A: if (phase_elapsed()) go_phase(PH_RT_B);
            PH_RT_B: if (phase_elapsed()) close_xfer(sffi2c_pkg::ST_OK, 0);
            default: begin
                stg = SG_NONE;
                go_phase(PH_IDLE);
            end
        endcase
    endfunction

    // one bus tick through the predicted engine
    function automatic sffi2c_pkg::result_t predict_tick(sffi2c_pkg::tick_t t);
        cur = '0;
        if (t.opcode == sffi2c_pkg::OP_LOAD && t.buffer_index < WDEPTH)
            wbuf[t.buffer_index] = t.data_byte;
        if (seq_ph != PH_IDLE) begin
            step_engine(t.scl_level, t.sda_level);
        end else if (t.opcode == sffi2c_pkg::OP_READ || t.opcode == sffi2c_pkg::OP_WRITE) begin
            is_write = (t.opcode == sffi2c_pkg::OP_WRITE);
            if (t.length == 0 || (is_write && t.length > WDEPTH)) begin
                close_xfer(sffi2c_pkg::ST_BAD_LEN, 0);
            end else begin
                dev_a = t.dev_address;
                reg_a = t.reg_address;
                ntotal = t.length;
                nbytes = 0;
                err_st = 0;
                ack_bit = 0;
                stg = SG_START1;
                go_phase(PH_ST_W);
            end
        end else if (t.opcode == sffi2c_pkg::OP_RECOVER) begin
            is_write = 0;
            nbytes = 0;
            ntotal = 0;
            err_st = 0;
            load_byte(SG_RCLK, 8'hff);
        end
        cur.scl_drive_low = scl_d;
        cur.sda_drive_low = sda_d;
        cur.busy_res = (seq_ph != PH_IDLE);
        return cur;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("result %0d: %s is %0h, expected %0h", n_results, what, got, want);
    endtask

    // result side: compare every transfer with the oldest expectation
    always @(posedge aclk) begin
        sffi2c_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, scl drive", m_scl_drive_low, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_scl_drive_low !== want.scl_drive_low)
                    report_mismatch("scl_drive_low", m_scl_drive_low, want.scl_drive_low);
                if (m_sda_drive_low !== want.sda_drive_low)
                    report_mismatch("sda_drive_low", m_sda_drive_low, want.sda_drive_low);
                if (m_busy_res !== want.busy_res)
                    report_mismatch("busy_res", m_busy_res, want.busy_res);
                if (m_read_data !== want.read_data)
                    report_mismatch("read_data", m_read_data, want.read_data);
                if (m_read_valid !== want.read_valid)
                    report_mismatch("read_valid", m_read_valid, want.read_valid);
                if (m_read_last !== want.read_last)
                    report_mismatch("read_last", m_read_last, want.read_last);
                if (m_done_res !== want.done_res)
                    report_mismatch("done_res", m_done_res, want.done_res);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_byte_count !== want.byte_count)
                    report_mismatch("byte_count", m_byte_count, want.byte_count);
                if (want.done_res) n_done++;
                if (want.read_valid) n_reads++;
                if (want.done_res && want.status != sffi2c_pkg::ST_OK) n_nacks++;
            end
            n_results++;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // offer one tick transfer, wait for it, then record what it should produce
    task automatic send_tick(input sffi2c_pkg::tick_t t, input bit typed,
                             input sffi2c_pkg::result_t typed_res);
        sffi2c_pkg::result_t r;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= t.opcode;
        s_dev_address  <= t.dev_address;
        s_reg_address  <= t.reg_address;
        s_length       <= t.length;
        s_buffer_index <= t.buffer_index;
        s_data_byte    <= t.data_byte;
        s_scl_level    <= t.scl_level;
        s_sda_level    <= t.sda_level;
        do @(posedge aclk); while (!s_ready);
        r = predict_tick(t);
        pending_results.push_back(typed ? typed_res : r);
        n_items++;
    endtask

    function automatic sffi2c_pkg::tick_t mk_tick(logic [2:0] op, logic [7:0] dev,
                                                  logic [7:0] rg, logic [7:0] len,
                                                  logic [2:0] idx, logic [7:0] dat,
                                                  bit scl, bit sda);
        sffi2c_pkg::tick_t t;
        t.opcode = op;
        t.dev_address = dev;
        t.reg_address = rg;
        t.length = len;
        t.buffer_index = idx;
        t.data_byte = dat;
        t.scl_level = scl;
        t.sda_level = sda;
        return t;
    endfunction

    function automatic sffi2c_pkg::tick_t rand_tick(logic [2:0] op, bit scl, bit sda);
        return mk_tick(op, 8'($urandom), 8'($urandom), 8'($urandom), 3'($urandom),
                       8'($urandom), scl, sda);
    endfunction

    // a tick while a transaction runs: mostly plain ticks, some loads and ignored commands
    function automatic sffi2c_pkg::tick_t busy_tick();
        int unsigned k;
        logic [2:0] op;
        k = $urandom_range(0, 19);
        if (k < 14) op = sffi2c_pkg::OP_TICK;
        else if (k < 17) op = sffi2c_pkg::OP_LOAD;
        else op = 3'($urandom_range(2, 7));
        return rand_tick(op, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
    endfunction

    // let the running transaction end with clean acks and no stretching
    task automatic run_to_idle();
        while (seq_ph != PH_IDLE)
            send_tick(rand_tick(sffi2c_pkg::OP_TICK, 1'b1, 1'b0), 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [0:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == sffi2c_pkg::CFG_PHASE) phase_lim_cfg = val;
        else stretch_lim_cfg = val;
    endtask

    task automatic set_timing(input logic [15:0] ph, input logic [15:0] st);
        apb_write(sffi2c_pkg::CFG_PHASE, ph);
        apb_write(sffi2c_pkg::CFG_STRETCH, st);
    endtask

    // random part: well-formed transactions with random content, plus noise
    task automatic run_random(input int unsigned budget);
        int unsigned stop_at, k;
        logic [2:0] bad_op;
        logic [7:0] bad_len;
        sffi2c_pkg::tick_t t;
        stop_at = n_items + budget;
        while (n_items < stop_at) begin
            k = $urandom_range(0, 19);
            if (k < 8)
                t = mk_tick(sffi2c_pkg::OP_READ, 8'($urandom), 8'($urandom),
                            8'($urandom_range(1, 4)), 3'($urandom), 8'($urandom),
                            1'($urandom), 1'($urandom));
            else if (k < 14)
                t = mk_tick(sffi2c_pkg::OP_WRITE, 8'($urandom), 8'($urandom),
                            8'($urandom_range(1, WDEPTH)), 3'($urandom), 8'($urandom),
                            1'($urandom), 1'($urandom));
            else if (k < 16)
                t = rand_tick(sffi2c_pkg::OP_RECOVER, 1'($urandom), 1'($urandom));
            else if (k < 18)
                t = rand_tick(sffi2c_pkg::OP_LOAD, 1'($urandom), 1'($urandom));
            else if (k < 19) begin
                // bad lengths: zero for either command, beyond the buffer for a write
                bad_op = ($urandom_range(0, 1) != 0) ? sffi2c_pkg::OP_WRITE
                                                     : sffi2c_pkg::OP_READ;
                if (bad_op == sffi2c_pkg::OP_READ || $urandom_range(0, 1) != 0)
                    bad_len = 8'd0;
                else
                    bad_len = 8'($urandom_range(9, 255));
                t = mk_tick(bad_op, 8'($urandom), 8'($urandom), bad_len,
                            3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end else
                t = rand_tick(3'($urandom_range(5, 7)), 1'($urandom), 1'($urandom));
            send_tick(t, 1'b0, '0);
            while (seq_ph != PH_IDLE && n_items < stop_at)
                send_tick(busy_tick(), 1'b0, '0);
        end
    endtask

    typedef struct {
        sffi2c_pkg::tick_t t;
        bit    typed;     // expectation read off directly
        bit    bad_len;   // typed row that ends at once with bad length
        bit    settle;    // let the bus run to idle after this row
    } stim_row_t;

    stim_row_t   dir_rows [$];
    sffi2c_pkg::result_t typed_res;
    logic [7:0]  fill [WDEPTH] = '{8'h00, 8'hff, 8'ha5, 8'h5a, 8'h01, 8'h80, 8'h7f, 8'hc3};

    initial begin
        phase_lim_cfg = sffi2c_pkg::PHASE_RESET;
        stretch_lim_cfg = sffi2c_pkg::STRETCH_RESET;
        seq_ph = PH_IDLE; ph_cnt = 0; str_cnt = 0; bit_cnt = 0; stg = SG_NONE;
        shreg = 0; nbytes = 0; ntotal = 0; dev_a = 0; reg_a = 0; err_st = 0;
        scl_d = 0; sda_d = 0; ack_bit = 0; is_write = 0;
        foreach (wbuf[i]) wbuf[i] = '0;

        // directed rows under reset timing: idle, every slot loaded, bad lengths, unused codes
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00,
                                     0, 0), 1, 0, 0});
        for (int i = 0; i < WDEPTH; i++)
            dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_LOAD, 8'hff, 8'hff, 8'hff, 3'(i),
                                         fill[i], 1, 1), 1, 0, 0});
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_READ, 8'ha0, 8'h00, 8'd0, 3'd0, 8'h00,
                                     1, 1), 1, 1, 0});
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_WRITE, 8'ha0, 8'h00, 8'd0, 3'd0, 8'h00,
                                     1, 1), 1, 1, 0});
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_WRITE, 8'ha1, 8'h10, 8'd9, 3'd0, 8'h00,
                                     1, 1), 1, 1, 0});
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_WRITE, 8'hff, 8'hff, 8'd255, 3'd7, 8'hff,
                                     0, 0), 1, 1, 0});
        dir_rows.push_back('{mk_tick(3'd5, 8'h00, 8'h00, 8'd1, 3'd0, 8'h00, 1, 1), 1, 0, 0});
        dir_rows.push_back('{mk_tick(3'd6, 8'h00, 8'h00, 8'd1, 3'd0, 8'h00, 1, 1), 1, 0, 0});
        dir_rows.push_back('{mk_tick(3'd7, 8'h00, 8'h00, 8'd1, 3'd0, 8'h00, 1, 1), 1, 0, 0});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            typed_res = '0;
            if (dir_rows[i].bad_len) begin
                typed_res.done_res = 1'b1;
                typed_res.status = sffi2c_pkg::ST_BAD_LEN;
            end
            send_tick(dir_rows[i].t, dir_rows[i].typed, typed_res);
        end
        wait_drained();

        // directed transactions on fast timing, checked by the predictor
        set_timing(16'd1, 16'd3);
        dir_rows.delete();
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_READ, 8'hff, 8'h00, 8'd2, 3'd0, 8'h00,
                                     1, 0), 0, 0, 0});
        // commands while busy are ignored
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_WRITE, 8'h00, 8'hff, 8'd3, 3'd0, 8'h00,
                                     1, 0), 0, 0, 0});
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_RECOVER, 8'h00, 8'hff, 8'd3, 3'd0, 8'h00,
                                     1, 0), 0, 0, 0});
        // a load while busy still stores
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_LOAD, 8'h00, 8'h00, 8'd0, 3'd3, 8'h3c,
                                     1, 0), 0, 0, 1});
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_WRITE, 8'h00, 8'hff, 8'd8, 3'd0, 8'h00,
                                     1, 0), 0, 0, 1});
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_RECOVER, 8'h55, 8'haa, 8'd0, 3'd0, 8'h00,
                                     1, 1), 0, 0, 1});
        dir_rows.push_back('{mk_tick(sffi2c_pkg::OP_WRITE, 8'ha0, 8'h01, 8'd1, 3'd0, 8'h00,
                                     1, 1), 0, 0, 0});
        foreach (dir_rows[i]) begin
            send_tick(dir_rows[i].t, 1'b0, '0);
            if (dir_rows[i].settle) run_to_idle();
        end
        // nack on the address byte: keep sda high throughout
        while (seq_ph != PH_IDLE)
            send_tick(rand_tick(sffi2c_pkg::OP_TICK, 1'b1, 1'b1), 1'b0, '0);
        wait_drained();

        // random with a long receiver hold-off so the input stalls
        hold_req = 1'b1;
        run_random(650);
        run_to_idle();
        wait_drained();

        // zero phase and zero stretch limits
        set_timing(16'd0, 16'd0);
        run_random(500);
        run_to_idle();
        wait_drained();

        // longest stretch limit
        set_timing(16'd2, 16'hffff);
        run_random(350);
        run_to_idle();
        wait_drained();

        // longest phase, shortest stretch, no idling on either side
        set_timing(16'hffff, 16'd1);
        quiet = 1'b1;
        run_random(200);
        wait_drained();

        $display("covered %0d tick transfers, %0d results, %0d finished transactions",
                 n_items, n_results, n_done);
        $display("%0d bytes read back, %0d transactions ended in error", n_reads, n_nacks);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sff_eeprom_i2c_master_unit.f
src/sffi2c_pkg.sv
src/sffi2c_front.sv
src/sffi2c_engine.sv
src/sff_eeprom_i2c_master_unit.sv
tb/tb_sff_eeprom_i2c_master_unit.sv
